// ----- hw/rtl/bnc_pkg.sv -----
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types and constants of the binary 3x3 neighbourhood count block.
// ----------------------------------------------------------------------------
`default_nettype none

package bnc_pkg;

    // configuration register widths and reset values
    localparam int ROWS_REG_W = 7;
    localparam int COLS_REG_W = 6;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd6;
    localparam logic [COLS_REG_W-1:0] COLS_RESET = 6'd6;

    // result field widths
    localparam int CNT_W     = 4;
    localparam int ROW_OUT_W = 6;
    localparam int COL_OUT_W = 5;

    // column sum of up to three bits
    localparam int CS_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_ROWS = 1'b0,
        CFG_IMAGE_COLS = 1'b1
    } t_cfg_index;

    // one image column across the two buffered rows
    typedef struct packed {
        logic prev;
        logic cur;
    } t_col;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_chain_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/bnc_cell.sv -----
// ----------------------------------------------------------------------------
// bnc_cell
// One column slot of the row buffer chain: two row bits, shifted towards
// the head, loaded with the newest column when it is the tail of the chain, cleared on clear.
// ----------------------------------------------------------------------------
`default_nettype none

module bnc_cell
    import bnc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_chain_ctl i_ctl,
    input  wire logic       i_is_tail,
    input  wire t_col       i_right,
    input  wire t_col       i_tail,
    output t_col            o_col
);

    t_col r_col;
    t_col n_col;

    always_comb begin
        n_col = r_col;
        priority if (i_ctl.clear) begin
            n_col = '0;
        end else if (i_ctl.shift) begin
            n_col = i_is_tail ? i_tail : i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

// ----- hw/rtl/bnc_chain.sv -----
// ----------------------------------------------------------------------------
// bnc_chain
// Row of column cells forming a circular line buffer whose length follows
// the configured column count; the head holds the column due next.
// ----------------------------------------------------------------------------
`default_nettype none

module bnc_chain
    import bnc_pkg::*;
#(
    parameter  int MAX_COLS = 32,
    localparam int CW       = $clog2(MAX_COLS)
) (
    input  wire logic          i_clk,
    input  wire t_chain_ctl    i_ctl,
    input  wire logic [CW-1:0] i_cols_last,
    input  wire t_col          i_tail,
    output t_col               o_head
);

    t_col w_cell  [MAX_COLS];
    t_col w_right [MAX_COLS];

    for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
        if (j == MAX_COLS - 1) begin : g_end
            assign w_right[j] = '0;
        end else begin : g_mid
            assign w_right[j] = w_cell[j+1];
        end

        bnc_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl),
            .i_is_tail (i_cols_last == CW'(j)),
            .i_right   (w_right[j]),
            .i_tail    (i_tail),
            .o_col     (w_cell[j])
        );
    end

    assign o_head = w_cell[0];

endmodule

`default_nettype wire

// ----- hw/rtl/binary_neighborhood_count_top.sv -----
// ----------------------------------------------------------------------------
// binary_neighborhood_count_top
// Streaming 3x3 box sum of a binary image, pixels in raster order.
//
//   channel   direction  handshake                 payload
//   pixel     in         i_in_valid / o_in_stall   i_pixel_set
//   count     out        o_out_valid / i_out_stall o_neighbor_count, o_out_row,
//                                                  o_out_col, o_run_last,
//                                                  o_frame_last
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// one pixel per cycle inside a row while the output is not stalled; the
// last pixel of a row from the second row on is followed by ST_TAIL for
// the row's final count; after the last pixel of a frame, ST_FLUSH moves
// the final row out of the cell chain and clears the chain at its end
// results go through one output register; a stalled output stalls input
// reset or any configuration write restarts the frame
// ----------------------------------------------------------------------------
`default_nettype none

module binary_neighborhood_count_top
    import bnc_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_pixel_set,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [CNT_W-1:0]           o_neighbor_count,
    output logic [ROW_OUT_W-1:0]       o_out_row,
    output logic [COL_OUT_W-1:0]       o_out_col,
    output logic                       o_run_last,
    output logic                       o_frame_last,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_COLS);
    localparam int FW = $clog2(MAX_COLS + 1);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_TAIL  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    function automatic logic [RW-1:0] f_rows_last(input logic [ROWS_REG_W-1:0] v);
        logic [RW-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (32'(v) > MAX_ROWS) begin
            res = RW'(MAX_ROWS - 1);
        end else begin
            res = RW'(v - ROWS_REG_W'(1));
        end
        return res;
    endfunction

    function automatic logic [CW-1:0] f_cols_last(input logic [COLS_REG_W-1:0] v);
        logic [CW-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (32'(v) > MAX_COLS) begin
            res = CW'(MAX_COLS - 1);
        end else begin
            res = CW'(v - COLS_REG_W'(1));
        end
        return res;
    endfunction

    t_state            r_state, n_state;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [FW-1:0]     r_fcnt, n_fcnt;
    logic [CS_W-1:0]   r_ws1, n_ws1;
    logic [CS_W-1:0]   r_ws2, n_ws2;
    logic [RW-1:0]     r_rows_last;
    logic [CW-1:0]     r_cols_last;

    logic              r_out_valid;
    logic [CNT_W-1:0]  r_count;
    logic [RW-1:0]     r_orow;
    logic [CW-1:0]     r_ocol;
    logic              r_run_last;
    logic              r_frame_last;

    t_chain_ctl        w_ctl;
    t_col              w_tail;
    t_col              w_head;
    logic              w_can_load;
    logic              w_in_acc;
    logic [CS_W-1:0]   w_cs_new;
    logic [CS_W-1:0]   w_cs_flush;
    logic              w_col_end;
    logic              w_col_first;
    logic              w_row_end;
    logic              w_row_first;
    logic              w_fcnt_end;

    logic              w_ld;
    logic [CNT_W-1:0]  w_count;
    logic [RW-1:0]     w_row;
    logic [CW-1:0]     w_ocol;
    logic              w_run;
    logic              w_frame;

    bnc_chain #(
        .MAX_COLS (MAX_COLS)
    ) u_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_cols_last (r_cols_last),
        .i_tail      (w_tail),
        .o_head      (w_head)
    );

    assign w_can_load  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == ST_RUN) && w_can_load);
    assign w_in_acc    = (r_state == ST_RUN) && w_can_load && i_in_valid;

    assign w_cs_new    = {1'b0, w_head.prev} + {1'b0, w_head.cur} + {1'b0, i_pixel_set};
    assign w_cs_flush  = (r_fcnt <= FW'(r_cols_last))
                       ? ({1'b0, w_head.prev} + {1'b0, w_head.cur}) : '0;

    assign w_col_end   = (r_col == r_cols_last);
    assign w_col_first = (r_col == '0);
    assign w_row_end   = (r_row == r_rows_last);
    assign w_row_first = (r_row == '0);
    assign w_fcnt_end  = (r_fcnt == FW'(r_cols_last) + FW'(1));

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_fcnt  = r_fcnt;
        n_ws1   = r_ws1;
        n_ws2   = r_ws2;
        w_ctl   = '0;
        w_tail  = '0;
        w_ld    = 1'b0;
        w_count = '0;
        w_row   = r_row;
        w_ocol  = r_col;
        w_run   = 1'b0;
        w_frame = 1'b0;

        unique case (r_state)
            ST_RUN: begin
                if (w_in_acc) begin
                    w_ctl.shift = 1'b1;
                    w_tail      = '{prev: w_head.cur, cur: i_pixel_set};
                    n_ws2       = w_col_first ? '0 : r_ws1;
                    n_ws1       = w_cs_new;
                    if (!w_row_first && !w_col_first) begin
                        w_ld    = 1'b1;
                        w_count = {2'b00, r_ws2} + {2'b00, r_ws1} + {2'b00, w_cs_new};
                        w_row   = r_row - RW'(1);
                        w_ocol  = r_col - CW'(1);
                        w_run   = !w_col_end;
                    end
                    if (w_col_end) begin
                        if (!w_row_first) begin
                            n_state = ST_TAIL;
                        end else if (w_row_end) begin
                            n_state = ST_FLUSH;
                            n_fcnt  = '0;
                        end else begin
                            n_row = r_row + RW'(1);
                            n_col = '0;
                        end
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            ST_TAIL: begin
                if (w_can_load) begin
                    w_ld    = 1'b1;
                    w_count = {2'b00, r_ws2} + {2'b00, r_ws1};
                    w_row   = r_row - RW'(1);
                    w_ocol  = r_cols_last;
                    w_run   = !w_row_end;
                    if (w_row_end) begin
                        n_state = ST_FLUSH;
                        n_fcnt  = '0;
                    end else begin
                        n_state = ST_RUN;
                        n_row   = r_row + RW'(1);
                        n_col   = '0;
                    end
                end
            end
            ST_FLUSH: begin
                if (r_fcnt == '0) begin
                    w_ctl.shift = 1'b1;
                    n_ws2       = '0;
                    n_ws1       = w_cs_flush;
                    n_fcnt      = r_fcnt + FW'(1);
                end else if (w_can_load) begin
                    w_ld        = 1'b1;
                    w_count     = {2'b00, r_ws2} + {2'b00, r_ws1} + {2'b00, w_cs_flush};
                    w_row       = r_row;
                    w_ocol      = CW'(r_fcnt - FW'(1));
                    w_run       = w_fcnt_end;
                    w_frame     = w_fcnt_end;
                    w_ctl.shift = 1'b1;
                    n_ws2       = r_ws1;
                    n_ws1       = w_cs_flush;
                    if (w_fcnt_end) begin
                        w_ctl.clear = 1'b1;
                        n_state     = ST_RUN;
                        n_row       = '0;
                        n_col       = '0;
                    end else begin
                        n_fcnt = r_fcnt + FW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase

        // any register write or reset restarts the frame
        if (i_cfg_we || !i_rst_n) begin
            w_ctl.clear = 1'b1;
            n_state     = ST_RUN;
            n_row       = '0;
            n_col       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_row       <= '0;
            r_col       <= '0;
            r_fcnt      <= '0;
            r_ws1       <= '0;
            r_ws2       <= '0;
            r_rows_last <= f_rows_last(ROWS_RESET);
            r_cols_last <= f_cols_last(COLS_RESET);
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_fcnt  <= n_fcnt;
            r_ws1   <= n_ws1;
            r_ws2   <= n_ws2;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_ROWS: begin
                        r_rows_last <= f_rows_last(i_cfg_data[ROWS_REG_W-1:0]);
                    end
                    CFG_IMAGE_COLS: begin
                        r_cols_last <= f_cols_last(i_cfg_data[COLS_REG_W-1:0]);
                    end
                    default: begin
                        r_rows_last <= r_rows_last;
                    end
                endcase
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_count      <= w_count;
            r_orow       <= w_row;
            r_ocol       <= w_ocol;
            r_run_last   <= w_run;
            r_frame_last <= w_frame;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_neighbor_count = r_count;
    assign o_out_row        = ROW_OUT_W'(r_orow);
    assign o_out_col        = COL_OUT_W'(r_ocol);
    assign o_run_last       = r_run_last;
    assign o_frame_last     = r_frame_last;

endmodule

`default_nettype wire
